### rtl/core/ccde_pkg.sv
// Shared types and constants for the character canvas draw engine.
`default_nettype none

package ccde_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_IN_USE = 2'd0,
    REG_COLS_IN_USE = 2'd1
  } reg_idx_t;

  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 6'd32;

  // Output code sent ahead of every rendered row but row zero
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  // Wide enough for row * cols + col with 8-bit row and column
  localparam int ADDR_CALC_W = 16;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PLOT   = 3'd1,
    CMD_HLINE  = 3'd2,
    CMD_VLINE  = 3'd3,
    CMD_RECT   = 3'd4,
    CMD_RENDER = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DRAW,
    ST_NEWLINE,
    ST_RENDER
  } state_t;

  // One straight run of cells: fixed row (horiz) or fixed column, lo..hi along the run
  typedef struct packed {
    logic       ok;
    logic       horiz;
    logic [7:0] fixed;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] ch;
  } span_t;

  // Build a run; it is dropped whole when any coordinate is off the canvas
  function automatic span_t make_span(input logic       horiz,
                                      input logic [7:0] fixed,
                                      input logic [7:0] a,
                                      input logic [7:0] b,
                                      input logic [7:0] ch,
                                      input logic [7:0] rows,
                                      input logic [7:0] cols);
    logic [7:0] lim_fixed;
    logic [7:0] lim_run;
    span_t      s;
    lim_fixed = horiz ? rows : cols;
    lim_run   = horiz ? cols : rows;
    s.ok      = (fixed < lim_fixed) && (a < lim_run) && (b < lim_run);
    s.horiz   = horiz;
    s.fixed   = fixed;
    s.lo      = (a > b) ? b : a;
    s.hi      = (a > b) ? a : b;
    s.ch      = ch;
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ccde_ifs.sv
// Channel interfaces: command items, rendered characters, register writes.
`default_nettype none

interface ccde_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] row_first;
  logic [7:0] row_second;
  logic [7:0] col_first;
  logic [7:0] col_second;
  logic [7:0] char_main;
  logic [7:0] char_vertical;
  logic [7:0] char_corner;

  modport source (output valid, command, row_first, row_second, col_first, col_second,
                  char_main, char_vertical, char_corner, input ready);
  modport sink   (input valid, command, row_first, row_second, col_first, col_second,
                  char_main, char_vertical, char_corner, output ready);
endinterface

interface ccde_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_last;

  modport source (output valid, out_char, is_last, input ready);
  modport sink   (input valid, out_char, is_last, output ready);
endinterface

interface ccde_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ccde_pkg::CFG_IDX_W-1:0]  index;
  logic [ccde_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/character_canvas_draw_engine_core.sv
// Top level of the character canvas draw engine.
//
// Channels: item (sink) takes one drawing command per transaction; result (source)
// streams the characters of a rendered row; cfg (sink) writes rows_in_use (index 0)
// and cols_in_use (index 1), always ready, meant to be used while the engine is idle.
// The canvas lives in one synchronous RAM, MAX_ROWS * MAX_COLS bytes, one access a
// cycle; the single write/read port sets the pace.
// Item steps, from acceptance until the engine is ready for the next one:
//   plot, line:  a setup step, then one write per cell of the run (none when dropped)
//   rectangle:   setup and writes for each of eight runs (a dropped run writes nothing)
//   clear:       a setup step and one write per cell for each row in use
//   render:      setup, a newline unless row 0, one read a cycle while result is taken
// Render reads are registered and land in a two-entry output queue; a read
// is only issued when the queue has room, so a stalled receiver just pauses the row
// and the last characters drain after the engine is ready again.
// Reset: rows_in_use and cols_in_use return to 32, the queue empties; canvas cells
// are undefined until a clear writes them.
`default_nettype none

module character_canvas_draw_engine_core #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire           clk,
  input  wire           rst,
  ccde_cmd_if.sink      item,
  ccde_result_if.source result,
  ccde_cfg_if.sink      cfg
);
  import ccde_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [CFG_DATA_W-1:0] rows_in_use;
  logic [CFG_DATA_W-1:0] cols_in_use;
  logic [7:0]            rows_eff;
  logic [7:0]            cols_eff;

  // Command held for the duration of the item
  logic [2:0] cmd_q;
  logic [7:0] r1_q, r2_q, c1_q, c2_q;
  logic [7:0] chm_q, chv_q, chc_q;

  state_t     state, state_next;
  logic [7:0] step;
  span_t      sp;
  span_t      seg;
  logic [7:0] pos;
  logic       more;
  logic       run_end;

  // Memory port
  logic [7:0]             row_sel, col_sel;
  logic [ADDR_CALC_W-1:0] addr_full;
  logic [AW-1:0]          cell_addr;
  logic                   mem_we, mem_re;
  logic [7:0]             mem [DEPTH];
  logic [7:0]             rd_data;
  logic                   rd_pending;
  logic                   rd_last;

  // Output queue
  logic [7:0] q_char [2];
  logic       q_last [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic [2:0] occ;
  logic       space;
  logic       nl_push, push, pop;

  // Config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_ROWS_IN_USE: rows_in_use <= cfg.data;
        REG_COLS_IN_USE: cols_in_use <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sizes in use, capped at the canvas dimensions
  assign rows_eff = ({2'b00, rows_in_use} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : {2'b00, rows_in_use};
  assign cols_eff = ({2'b00, cols_in_use} > 8'(MAX_COLS)) ? 8'(MAX_COLS) : {2'b00, cols_in_use};

  // Run for the current step of the command
  always_comb begin
    sp = '0;
    unique case (cmd_t'(cmd_q))
      CMD_CLEAR:  sp = make_span(1'b1, step, 8'd0, cols_eff - 8'd1, chm_q, rows_eff, cols_eff);
      CMD_PLOT:   sp = make_span(1'b1, r1_q, c1_q, c1_q, chm_q, rows_eff, cols_eff);
      CMD_HLINE:  sp = make_span(1'b1, r1_q, c1_q, c2_q, chm_q, rows_eff, cols_eff);
      CMD_VLINE:  sp = make_span(1'b0, c1_q, r1_q, r2_q, chm_q, rows_eff, cols_eff);
      CMD_RENDER: sp = make_span(1'b1, r1_q, 8'd0, cols_eff - 8'd1, 8'd0, rows_eff, cols_eff);
      CMD_RECT: begin
        case (step[2:0])
          3'd0:    sp = make_span(1'b1, r1_q, c1_q, c2_q, chm_q, rows_eff, cols_eff);
          3'd1:    sp = make_span(1'b1, r2_q, c1_q, c2_q, chm_q, rows_eff, cols_eff);
          3'd2:    sp = make_span(1'b0, c1_q, r1_q, r2_q, chv_q, rows_eff, cols_eff);
          3'd3:    sp = make_span(1'b0, c2_q, r1_q, r2_q, chv_q, rows_eff, cols_eff);
          3'd4:    sp = make_span(1'b1, r1_q, c1_q, c1_q, chc_q, rows_eff, cols_eff);
          3'd5:    sp = make_span(1'b1, r1_q, c2_q, c2_q, chc_q, rows_eff, cols_eff);
          3'd6:    sp = make_span(1'b1, r2_q, c1_q, c1_q, chc_q, rows_eff, cols_eff);
          default: sp = make_span(1'b1, r2_q, c2_q, c2_q, chc_q, rows_eff, cols_eff);
        endcase
      end
      default: sp = '0;
    endcase
  end

  // Another step follows: next clear row, or next rectangle part
  assign more = ((cmd_q == CMD_CLEAR) && ((9'(step) + 9'd1) < 9'(rows_eff))) ||
                ((cmd_q == CMD_RECT) && (step[2:0] != 3'd7));
  assign run_end = (pos == seg.hi);

  // Queue room once this cycle's pop and any read in flight are counted
  assign pop   = result.valid & result.ready;
  assign occ   = 3'(count) + 3'(rd_pending) - 3'(pop);
  assign space = (occ < 3'd2);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (cmd_q == CMD_RENDER) begin
          if (!sp.ok)            state_next = ST_IDLE;
          else if (r1_q != 8'd0) state_next = ST_NEWLINE;
          else                   state_next = ST_RENDER;
        end else if (sp.ok) begin
          state_next = ST_DRAW;
        end else if (!more) begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAW: begin
        if (run_end) state_next = more ? ST_SETUP : ST_IDLE;
      end
      ST_NEWLINE: begin
        if (space) state_next = ST_RENDER;
      end
      ST_RENDER: begin
        if (space && run_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    nl_push    = 1'b0;
    unique case (state)
      ST_IDLE:    item.ready = 1'b1;
      ST_DRAW:    mem_we     = 1'b1;
      ST_NEWLINE: nl_push    = space;
      ST_RENDER:  mem_re     = space;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Command capture, step and run position
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            cmd_q <= item.command;
            r1_q  <= item.row_first;
            r2_q  <= item.row_second;
            c1_q  <= item.col_first;
            c2_q  <= item.col_second;
            chm_q <= item.char_main;
            chv_q <= item.char_vertical;
            chc_q <= item.char_corner;
            step  <= '0;
          end
        end
        ST_SETUP: begin
          seg <= sp;
          pos <= sp.lo;
          if (!sp.ok && more) step <= step + 8'd1;
        end
        ST_DRAW: begin
          pos <= pos + 8'd1;
          if (run_end) step <= step + 8'd1;
        end
        ST_RENDER: begin
          if (space) pos <= pos + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // Cell address: row * MAX_COLS + col
  assign row_sel   = seg.horiz ? seg.fixed : pos;
  assign col_sel   = seg.horiz ? pos : seg.fixed;
  assign addr_full = ADDR_CALC_W'(row_sel) * ADDR_CALC_W'(MAX_COLS) + ADDR_CALC_W'(col_sel);
  assign cell_addr = addr_full[AW-1:0];

  // Canvas RAM
  always_ff @(posedge clk) begin
    if (mem_we) mem[cell_addr] <= seg.ch;
    if (mem_re) rd_data <= mem[cell_addr];
  end

  // Read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= mem_re;
    end
    if (mem_re) rd_last <= run_end;
  end

  // Two-entry output queue
  assign push = rd_pending | nl_push;

  always_ff @(posedge clk) begin
    if (push) begin
      q_char[wptr] <= nl_push ? NEWLINE_CHAR : rd_data;
      q_last[wptr] <= nl_push ? 1'b0 : rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign result.valid    = (count != 2'd0);
  assign result.out_char = q_char[rptr];
  assign result.is_last  = q_last[rptr];

endmodule

`default_nettype wire
